// ----- sv/fwq_pkg.sv -----
// Shared codes, payload types and default sizes for the futex wait queue engine.
`default_nettype none

package fwq_pkg;

  localparam int TABLE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 16;

  localparam logic [2:0] CMD_WAIT        = 3'd0;
  localparam logic [2:0] CMD_WAKE        = 3'd1;
  localparam logic [2:0] CMD_FD          = 3'd2;
  localparam logic [2:0] CMD_REQUEUE     = 3'd3;
  localparam logic [2:0] CMD_CMP_REQUEUE = 3'd4;
  localparam logic [2:0] CMD_WAKE_OP     = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SUSPENDED   = 3'd1;
  localparam logic [2:0] ST_TRY_AGAIN   = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        futex_addr;
    logic [31:0]        target_addr;
    logic [15:0]        caller_thread;
    logic signed [31:0] expected_value;
    logic signed [31:0] current_value;
    logic [30:0]        wake_limit;
    logic [30:0]        move_limit;
    logic               timeout_given;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] woken_thread;
    logic [2:0]  status;
    logic [4:0]  done_count;
    logic        last_result;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/fwq_if.sv -----
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface fwq_req_if;
  import fwq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fwq_rsp_if;
  import fwq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/futex_wait_queue_engine_top.sv -----
// Futex wait queue engine: waiter table with wait, wake and requeue sequencing.
//
// The waiter table is a single memory kept packed, with new and moved waiters
// appended at its end, and one sequencer walks it one entry per cycle unless
// a wake notice waits for the output register. A wait or an unsupported
// command goes from idle to the final state, which writes its status into
// the output register once that is free. A wake makes one pass over the
// queued waiters; a requeue makes a wake pass, then a move scan over the
// waiters left and an append of the moved waiters, each its own pass over
// the table port. The block takes no new request until the current one has
// produced its final result into the output register, which then waits for
// its transfer on its own.
`default_nettype none

module futex_wait_queue_engine_top #(
  parameter int TABLE_DEPTH    = fwq_pkg::TABLE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = fwq_pkg::THREAD_ID_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  fwq_req_if.sink    in_ch,
  fwq_rsp_if.source  out_ch
);
  import fwq_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TB = THREAD_ID_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WAKE   = 3'd1;
  localparam logic [2:0] S_MOVE   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  // Waiter table and staging memory for threads being moved
  logic [31:0]   tbl_addr   [TABLE_DEPTH];
  logic [TB-1:0] tbl_thread [TABLE_DEPTH];
  logic [TB-1:0] mt_thread  [TABLE_DEPTH];
  logic [31:0]   rd_addr;
  logic [TB-1:0] rd_thread;
  logic [TB-1:0] mt_rd_thread;

  logic [2:0]    state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] keep, keep_next;
  logic [CW-1:0] woken, woken_next;
  logic [CW-1:0] moved, moved_next;

  logic [31:0]   req_faddr, req_taddr;
  logic [30:0]   req_wlim, req_mlim;
  logic          req_requeue;
  logic [2:0]    fin_status, fin_status_next;
  logic          accept;

  logic          out_valid, out_valid_next;
  rsp_t          out_data, out_data_next;
  logic          out_free;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_addr;
  logic [TB-1:0] wr_thread;
  logic          mt_wr_en;

  logic [TB+15:0] caller_wide;
  logic [TB+15:0] rd_thread_wide;
  logic [CW+5:0]  count_sum;
  logic [CW-1:0]  append_idx;
  logic           wake_hit, move_hit;

  assign in_ch.ready  = (state == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign out_free     = !out_valid || out_ch.ready;

  assign caller_wide    = {{TB{1'b0}}, in_ch.data.caller_thread};
  assign rd_thread_wide = {16'b0, rd_thread};
  assign count_sum      = {6'b0, woken} + {6'b0, moved};
  assign append_idx     = keep + idx;

  assign wake_hit = (rd_addr == req_faddr) &&
                    ({{(31-CW){1'b0}}, woken} < req_wlim);
  assign move_hit = (rd_addr == req_faddr) &&
                    ({{(31-CW){1'b0}}, moved} < req_mlim);

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    idx_next        = idx;
    keep_next       = keep;
    woken_next      = woken;
    moved_next      = moved;
    fin_status_next = fin_status;
    out_valid_next  = out_valid && !out_ch.ready;
    out_data_next   = out_data;
    wr_en           = 1'b0;
    wr_idx          = keep[IW-1:0];
    wr_addr         = rd_addr;
    wr_thread       = rd_thread;
    mt_wr_en        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          keep_next  = '0;
          woken_next = '0;
          moved_next = '0;
          unique case (in_ch.data.command)
            CMD_WAIT: begin
              state_next = S_FIN;
              if (in_ch.data.timeout_given) begin
                fin_status_next = ST_UNSUPPORTED;
              end else if (in_ch.data.current_value != in_ch.data.expected_value) begin
                fin_status_next = ST_TRY_AGAIN;
              end else if (fill == CW'(TABLE_DEPTH)) begin
                fin_status_next = ST_TABLE_FULL;
              end else begin
                fin_status_next = ST_SUSPENDED;
                wr_en     = 1'b1;
                wr_idx    = fill[IW-1:0];
                wr_addr   = in_ch.data.futex_addr;
                wr_thread = caller_wide[TB-1:0];
                fill_next = fill + 1'b1;
              end
            end
            CMD_WAKE: begin
              if (in_ch.data.timeout_given) begin
                state_next      = S_FIN;
                fin_status_next = ST_UNSUPPORTED;
              end else begin
                state_next      = S_WAKE;
                fin_status_next = ST_OK;
              end
            end
            CMD_REQUEUE: begin
              state_next      = S_WAKE;
              fin_status_next = ST_OK;
            end
            default: begin
              state_next      = S_FIN;
              fin_status_next = ST_UNSUPPORTED;
            end
          endcase
        end
      end

      S_WAKE: begin
        if (idx == fill) begin
          fill_next  = keep;
          idx_next   = '0;
          keep_next  = '0;
          state_next = req_requeue ? S_MOVE : S_FIN;
        end else if (wake_hit) begin
          // Hold the scan until the output register can take the notice
          if (out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = '{result_kind: KIND_NOTICE,
                               woken_thread: rd_thread_wide[15:0],
                               status: ST_OK, done_count: 5'd0,
                               last_result: 1'b0};
            woken_next = woken + 1'b1;
            idx_next   = idx + 1'b1;
          end
        end else begin
          wr_en     = 1'b1;
          keep_next = keep + 1'b1;
          idx_next  = idx + 1'b1;
        end
      end

      S_MOVE: begin
        if (idx == fill) begin
          idx_next   = '0;
          state_next = S_APPEND;
        end else begin
          if (move_hit) begin
            mt_wr_en   = 1'b1;
            moved_next = moved + 1'b1;
          end else begin
            wr_en     = 1'b1;
            keep_next = keep + 1'b1;
          end
          idx_next = idx + 1'b1;
        end
      end

      S_APPEND: begin
        if (idx == moved) begin
          state_next = S_FIN;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = append_idx[IW-1:0];
          wr_addr   = req_taddr;
          wr_thread = mt_rd_thread;
          idx_next  = idx + 1'b1;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{result_kind: KIND_FINAL, woken_thread: 16'd0,
                             status: fin_status, done_count: count_sum[4:0],
                             last_result: 1'b1};
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Table and staging memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_addr[wr_idx]   <= wr_addr;
      tbl_thread[wr_idx] <= wr_thread;
    end
    if (mt_wr_en) begin
      mt_thread[moved[IW-1:0]] <= rd_thread;
    end
    rd_addr      <= tbl_addr[idx_next[IW-1:0]];
    rd_thread    <= tbl_thread[idx_next[IW-1:0]];
    mt_rd_thread <= mt_thread[idx_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    keep       <= keep_next;
    woken      <= woken_next;
    moved      <= moved_next;
    fin_status <= fin_status_next;
    out_data   <= out_data_next;
    if (accept) begin
      req_faddr   <= in_ch.data.futex_addr;
      req_taddr   <= in_ch.data.target_addr;
      req_wlim    <= in_ch.data.wake_limit;
      req_mlim    <= in_ch.data.move_limit;
      req_requeue <= (in_ch.data.command == CMD_REQUEUE);
    end
  end

endmodule

`default_nettype wire
